/* src/iercoal_pkg.sv */
`default_nettype none

package iercoal_pkg;

   // Width of the motion and wheel accumulators (8 to 32).
   localparam int DELTA_WIDTH = 16;
   // The sum of an accumulator and a 32-bit event value, one bit of headroom.
   localparam int SUM_WIDTH   = ((DELTA_WIDTH > 32) ? DELTA_WIDTH : 32) + 1;
   localparam int OUT_DELTA_WIDTH = 16;
   localparam int BUTTON_COUNT    = 5;

   localparam logic signed [DELTA_WIDTH-1:0] DELTA_MAX = {1'b0, {(DELTA_WIDTH-1){1'b1}}};
   localparam logic signed [DELTA_WIDTH-1:0] DELTA_MIN = {1'b1, {(DELTA_WIDTH-1){1'b0}}};

   // Source device.
   localparam logic SRC_KEYBOARD = 1'b0;
   localparam logic SRC_POINTER  = 1'b1;

   // Event types.
   localparam logic [4:0] EV_SYN = 5'd0;
   localparam logic [4:0] EV_KEY = 5'd1;
   localparam logic [4:0] EV_REL = 5'd2;

   // Event codes.
   localparam logic [15:0] SYNC_FLUSH  = 16'd0;
   localparam logic [15:0] SYNC_LOST   = 16'd3;
   localparam logic [15:0] REL_X       = 16'd0;
   localparam logic [15:0] REL_Y       = 16'd1;
   localparam logic [15:0] REL_HSCROLL = 16'd6;
   localparam logic [15:0] REL_VSCROLL = 16'd8;
   localparam logic [15:0] KEY_FIRST   = 16'd1;
   localparam logic [15:0] KEY_LAST    = 16'd767;
   localparam logic [15:0] BTN_FIRST   = 16'h0110;
   localparam logic [15:0] BTN_LAST    = 16'h0114;

   // Result kinds.
   localparam logic [1:0] KIND_KEY      = 2'd0;
   localparam logic [1:0] KIND_REPORT   = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   typedef struct packed {
      logic               source;
      logic [4:0]         ev_class;
      logic [15:0]        event_code;
      logic signed [31:0] event_value;
   } event_req_type;

   typedef struct packed {
      logic [1:0]                         result_kind;
      logic [31:0]                        stream_tag;
      logic [9:0]                         key_code;
      logic [1:0]                         key_state;
      logic signed [OUT_DELTA_WIDTH-1:0]  delta_x;
      logic signed [OUT_DELTA_WIDTH-1:0]  delta_y;
      logic signed [OUT_DELTA_WIDTH-1:0]  wheel_vert;
      logic signed [OUT_DELTA_WIDTH-1:0]  wheel_horiz;
      logic [BUTTON_COUNT-1:0]            button_bits;
   } rsp_type;

   // Saturating add of a signed event value into an accumulator.
   function automatic logic signed [DELTA_WIDTH-1:0] sat_add(
      input logic signed [DELTA_WIDTH-1:0] acc,
      input logic signed [31:0]            val
   );
      logic signed [SUM_WIDTH-1:0] sum;
      logic signed [SUM_WIDTH-1:0] hi;
      logic signed [SUM_WIDTH-1:0] lo;
      sum = SUM_WIDTH'(acc) + SUM_WIDTH'(val);
      hi  = SUM_WIDTH'(DELTA_MAX);
      lo  = SUM_WIDTH'(DELTA_MIN);
      if (sum > hi) begin
         return DELTA_MAX;
      end else if (sum < lo) begin
         return DELTA_MIN;
      end
      return sum[DELTA_WIDTH-1:0];
   endfunction

   // Low bits of the sign-extended accumulator, as the result field carries them.
   function automatic logic signed [OUT_DELTA_WIDTH-1:0] to_out_delta(
      input logic signed [DELTA_WIDTH-1:0] acc
   );
      logic [OUT_DELTA_WIDTH+DELTA_WIDTH-1:0] ext;
      ext = {{OUT_DELTA_WIDTH{acc[DELTA_WIDTH-1]}}, acc};
      return ext[OUT_DELTA_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

/* src/iercoal_in_stage.sv */
`default_nettype none

module iercoal_in_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire iercoal_pkg::event_req_type req_event,
   input  wire logic                      pop,
   output      logic                      held_valid,
   output      iercoal_pkg::event_req_type held_event
);
   import iercoal_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   event_req_type event_ff;

   // The stage refills in the same cycle that its request moves on.
   assign req_ready = !valid_ff || pop;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         event_ff <= req_event;
      end
   end

   assign held_valid = valid_ff;
   assign held_event = event_ff;

endmodule

`default_nettype wire

/* src/iercoal_engine.sv */
`default_nettype none

module iercoal_engine (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      held_valid,
   input  wire iercoal_pkg::event_req_type held_event,
   input  wire logic                      out_free,
   input  wire logic [31:0]               stream_id,
   output      logic                      pop,
   output      logic                      has_result,
   output      iercoal_pkg::rsp_type      result
);
   import iercoal_pkg::*;

   logic signed [DELTA_WIDTH-1:0] acc_dx_ff, acc_dx_in;
   logic signed [DELTA_WIDTH-1:0] acc_dy_ff, acc_dy_in;
   logic signed [DELTA_WIDTH-1:0] acc_wheel_v_ff, acc_wheel_v_in;
   logic signed [DELTA_WIDTH-1:0] acc_wheel_h_ff, acc_wheel_h_in;
   logic [BUTTON_COUNT-1:0]       held_buttons_ff, held_buttons_in;
   logic                          report_pending_ff, report_pending_in;
   logic                          halted_ff, halted_in;

   logic        is_dropped;
   logic        is_key_fwd;
   logic        is_btn;
   logic        is_report;
   logic        val_is_state;
   logic [BUTTON_COUNT-1:0] btn_bit;

   assign pop = held_valid && out_free;

   assign val_is_state = (held_event.event_value[31:2] == 30'd0)
                         && (held_event.event_value[1:0] != 2'd3);
   assign is_dropped = (held_event.ev_class == EV_SYN)
                       && (held_event.event_code == SYNC_LOST);
   assign is_key_fwd = (held_event.source == SRC_KEYBOARD)
                       && (held_event.ev_class == EV_KEY)
                       && (held_event.event_code >= KEY_FIRST)
                       && (held_event.event_code <= KEY_LAST) && val_is_state;
   assign is_btn     = (held_event.source == SRC_POINTER)
                       && (held_event.ev_class == EV_KEY)
                       && (held_event.event_code >= BTN_FIRST)
                       && (held_event.event_code <= BTN_LAST);
   assign is_report  = (held_event.source == SRC_POINTER)
                       && (held_event.ev_class == EV_SYN)
                       && (held_event.event_code == SYNC_FLUSH);
   // Button codes start on an aligned boundary, so the low bits pick the bit.
   assign btn_bit = BUTTON_COUNT'(1) << held_event.event_code[2:0];

   always_comb begin
      acc_dx_in         = acc_dx_ff;
      acc_dy_in         = acc_dy_ff;
      acc_wheel_v_in    = acc_wheel_v_ff;
      acc_wheel_h_in    = acc_wheel_h_ff;
      held_buttons_in   = held_buttons_ff;
      report_pending_in = report_pending_ff;
      halted_in         = halted_ff;
      has_result        = 1'b0;
      result            = '0;
      result.stream_tag = stream_id;

      if (!halted_ff) begin
         if (is_dropped) begin
            halted_in          = 1'b1;
            has_result         = 1'b1;
            result.result_kind = KIND_OVERFLOW;
         end else if (is_key_fwd) begin
            has_result         = 1'b1;
            result.result_kind = KIND_KEY;
            result.key_code    = held_event.event_code[9:0];
            result.key_state   = held_event.event_value[1:0];
         end else if (held_event.source == SRC_POINTER
                      && held_event.ev_class == EV_REL) begin
            case (held_event.event_code)
               REL_X: begin
                  acc_dx_in         = sat_add(acc_dx_ff, held_event.event_value);
                  report_pending_in = 1'b1;
               end
               REL_Y: begin
                  acc_dy_in         = sat_add(acc_dy_ff, held_event.event_value);
                  report_pending_in = 1'b1;
               end
               REL_VSCROLL: begin
                  acc_wheel_v_in    = sat_add(acc_wheel_v_ff, held_event.event_value);
                  report_pending_in = 1'b1;
               end
               REL_HSCROLL: begin
                  acc_wheel_h_in    = sat_add(acc_wheel_h_ff, held_event.event_value);
                  report_pending_in = 1'b1;
               end
               default: begin
               end
            endcase
         end else if (is_btn) begin
            if (held_event.event_value != 32'sd0) begin
               held_buttons_in = held_buttons_ff | btn_bit;
            end else begin
               held_buttons_in = held_buttons_ff & ~btn_bit;
            end
            report_pending_in = 1'b1;
         end else if (is_report && report_pending_ff) begin
            has_result         = 1'b1;
            result.result_kind = KIND_REPORT;
            result.delta_x     = to_out_delta(acc_dx_ff);
            result.delta_y     = to_out_delta(acc_dy_ff);
            result.wheel_vert  = to_out_delta(acc_wheel_v_ff);
            result.wheel_horiz = to_out_delta(acc_wheel_h_ff);
            result.button_bits = held_buttons_ff;
            acc_dx_in          = '0;
            acc_dy_in          = '0;
            acc_wheel_v_in     = '0;
            acc_wheel_h_in     = '0;
            report_pending_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_dx_ff         <= '0;
         acc_dy_ff         <= '0;
         acc_wheel_v_ff    <= '0;
         acc_wheel_h_ff    <= '0;
         held_buttons_ff   <= '0;
         report_pending_ff <= 1'b0;
         halted_ff         <= 1'b0;
      end else if (pop) begin
         acc_dx_ff         <= acc_dx_in;
         acc_dy_ff         <= acc_dy_in;
         acc_wheel_v_ff    <= acc_wheel_v_in;
         acc_wheel_h_ff    <= acc_wheel_h_in;
         held_buttons_ff   <= held_buttons_in;
         report_pending_ff <= report_pending_in;
         halted_ff         <= halted_in;
      end
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !has_result)
      else $error("halted block produced a result");

   a_overflow_halts: assert property (@(posedge clock) disable iff (reset)
      (pop && has_result && result.result_kind == KIND_OVERFLOW) |=> halted_ff)
      else $error("overflow result did not halt the block");

   a_report_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && has_result && result.result_kind == KIND_REPORT)
      |=> (!report_pending_ff && acc_dx_ff == '0 && acc_dy_ff == '0))
      else $error("report did not clear pending state");

endmodule

`default_nettype wire

/* src/iercoal_out_stage.sv */
`default_nettype none

module iercoal_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire iercoal_pkg::rsp_type load_result,
   input  wire logic                 rsp_ready,
   output      logic                 out_free,
   output      logic                 rsp_valid,
   output      iercoal_pkg::rsp_type rsp_result
);
   import iercoal_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type result_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = out_free ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && load) begin
         result_ff <= load_result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

/* src/input_event_report_coalescer_core.sv */
// Input event report coalescer.
//
// Requests enter on the req_ channel (valid/ready), one input event each:
// source device, evdev type, code and signed value. Results leave on the
// rsp_ channel (valid/ready), at most one per request: a forwarded keyboard
// key, a coalesced pointer report, or an overflow error. The csr_ channel
// writes the stream identifier that is copied into every result; it is
// always ready and should only be written while no request is in flight.
//
// A request is accepted into the input register and its result is then
// loaded into the result register, where rsp_valid marks it for the
// receiver. One request per cycle is sustained while rsp_ready stays high,
// with the decode and saturating add combinational between the two
// registers. When the receiver stalls, the result register holds its result
// and the input register holds one more request; req_ready then drops until
// rsp_ready returns.
//
// Reset clears the accumulators, buttons, pending and halt flags, both
// stage valid bits and the stream identifier. After a dropped-sync event
// the block swallows every request until the next reset.
`default_nettype none

module input_event_report_coalescer_core (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_source,
   input  wire logic [4:0]  req_ev_class,
   input  wire logic [15:0] req_event_code,
   input  wire logic signed [31:0] req_event_value,

   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_result_kind,
   output      logic [31:0] rsp_stream_tag,
   output      logic [9:0]  rsp_key_code,
   output      logic [1:0]  rsp_key_state,
   output      logic signed [15:0] rsp_delta_x,
   output      logic signed [15:0] rsp_delta_y,
   output      logic signed [15:0] rsp_wheel_vert,
   output      logic signed [15:0] rsp_wheel_horiz,
   output      logic [4:0]  rsp_button_bits,

   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [31:0] csr_stream_id
);
   import iercoal_pkg::*;

   logic          stream_id_ff;
   logic [31:0]   stream_id_reg_ff;
   event_req_type req_event;
   event_req_type held_event;
   logic          held_valid;
   logic          pop;
   logic          has_result;
   logic          out_free;
   rsp_type       result;
   rsp_type       rsp_result;

   // The stream identifier register takes a write in any cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_id_reg_ff <= '0;
         stream_id_ff     <= 1'b0;
      end else if (csr_valid) begin
         stream_id_reg_ff <= csr_stream_id;
         stream_id_ff     <= 1'b1;
      end
   end

   assign req_event.source      = req_source;
   assign req_event.ev_class    = req_ev_class;
   assign req_event.event_code  = req_event_code;
   assign req_event.event_value = req_event_value;

   // Input register: holds one request while the engine waits for room.
   iercoal_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_event  (req_event),
      .pop        (pop),
      .held_valid (held_valid),
      .held_event (held_event)
   );

   // Decode, accumulate and build the result.
   iercoal_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .held_valid (held_valid),
      .held_event (held_event),
      .out_free   (out_free),
      .stream_id  (stream_id_reg_ff),
      .pop        (pop),
      .has_result (has_result),
      .result     (result)
   );

   // Result register: parts the engine from a stalled receiver.
   iercoal_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (pop && has_result),
      .load_result (result),
      .rsp_ready   (rsp_ready),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_result  (rsp_result)
   );

   assign rsp_result_kind = rsp_result.result_kind;
   assign rsp_stream_tag  = rsp_result.stream_tag;
   assign rsp_key_code    = rsp_result.key_code;
   assign rsp_key_state   = rsp_result.key_state;
   assign rsp_delta_x     = rsp_result.delta_x;
   assign rsp_delta_y     = rsp_result.delta_y;
   assign rsp_wheel_vert  = rsp_result.wheel_vert;
   assign rsp_wheel_horiz = rsp_result.wheel_horiz;
   assign rsp_button_bits = rsp_result.button_bits;

   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while the receiver stalled");

   a_stream_written: assert property (@(posedge clock) disable iff (reset)
      (stream_id_ff == 1'b0) |-> (stream_id_reg_ff == 32'd0))
      else $error("stream identifier changed without a write");

   a_config_tracks: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> (stream_id_reg_ff == $past(csr_stream_id)))
      else $error("stream identifier write lost");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps

// Testbench for input_event_report_coalescer_core.
//
// A queue of pending input events is filled by the main initial block and
// drained by a clocked driver that changes the request channel at the
// falling edge. A clocked monitor samples both channels at the rising edge.
// Every accepted request goes through a local predictor of the coalescer,
// and any result it predicts is queued. Every accepted result is checked
// field by field against the oldest queued prediction.
//
// Because a dropped-sync event halts the block until reset, and reset is
// applied only once, the overflow error is the very last result of the run.
module tb;
   import iercoal_pkg::*;

   localparam int  LATENCY_SLACK    = 6;       // idle cycles after the last result
   localparam int  CYCLE_LIMIT      = 200000;
   localparam int  ITEMS_PER_PHASE  = 305;
   localparam int  LONG_HOLD_AT     = 400;     // accepted requests before the long hold
   localparam int  LONG_HOLD_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_source = 1'b0;
   logic [4:0]  req_ev_class = '0;
   logic [15:0] req_event_code = '0;
   logic signed [31:0] req_event_value = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [31:0] rsp_stream_tag;
   logic [9:0]  rsp_key_code;
   logic [1:0]  rsp_key_state;
   logic signed [15:0] rsp_delta_x;
   logic signed [15:0] rsp_delta_y;
   logic signed [15:0] rsp_wheel_vert;
   logic signed [15:0] rsp_wheel_horiz;
   logic [4:0]  rsp_button_bits;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_stream_id = '0;

   input_event_report_coalescer_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_source      (req_source),
      .req_ev_class    (req_ev_class),
      .req_event_code  (req_event_code),
      .req_event_value (req_event_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_stream_tag  (rsp_stream_tag),
      .rsp_key_code    (rsp_key_code),
      .rsp_key_state   (rsp_key_state),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_wheel_vert  (rsp_wheel_vert),
      .rsp_wheel_horiz (rsp_wheel_horiz),
      .rsp_button_bits (rsp_button_bits),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_stream_id   (csr_stream_id)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Stimulus and bookkeeping shared between the processes.
   event_req_type event_backlog[$];
   rsp_type       predicted_results[$];
   int  queued_events      = 0;
   int  requests_issued    = 0;
   int  requests_accepted  = 0;
   int  mismatch_count     = 0;
   int  key_results        = 0;
   int  pointer_reports    = 0;
   int  overflow_results   = 0;
   int  csr_writes         = 0;
   int  backpressure_cycles = 0;
   int  cycle_count        = 0;
   bit  idling_on          = 1'b0;
   bit  req_taken          = 1'b0;

   // Local copy of the coalescer state. It starts at its reset values.
   logic signed [DELTA_WIDTH-1:0] motion_x    = '0;
   logic signed [DELTA_WIDTH-1:0] motion_y    = '0;
   logic signed [DELTA_WIDTH-1:0] wheel_v_sum = '0;
   logic signed [DELTA_WIDTH-1:0] wheel_h_sum = '0;
   logic [BUTTON_COUNT-1:0]       buttons_held = '0;
   bit                            report_waiting = 1'b0;
   bit                            block_halted   = 1'b0;
   logic [31:0]                   tag_setting    = '0;

   // Adds a 32-bit signed step to an accumulator, pinning it at the rails.
   function automatic logic signed [DELTA_WIDTH-1:0] clamp_add(
      input logic signed [DELTA_WIDTH-1:0] acc,
      input logic signed [31:0]            step
   );
      longint total;
      total = longint'(acc) + longint'(step);
      if (total > longint'(DELTA_MAX)) begin
         return DELTA_MAX;
      end
      if (total < longint'(DELTA_MIN)) begin
         return DELTA_MIN;
      end
      return total[DELTA_WIDTH-1:0];
   endfunction

   // Applies one accepted event to the local state and tells whether the
   // block owes a result for it.
   function automatic void coalesce_event(input event_req_type ev, output bit emits,
                                          output rsp_type res);
      logic [2:0] button_index;
      emits = 1'b0;
      res = '0;
      res.stream_tag = tag_setting;
      if (block_halted) begin
         return;
      end
      // A dropped sync from either device is fatal.
      if (ev.ev_class == EV_SYN && ev.event_code == SYNC_LOST) begin
         block_halted = 1'b1;
         res.result_kind = KIND_OVERFLOW;
         emits = 1'b1;
         return;
      end
      if (ev.source == SRC_KEYBOARD) begin
         if (ev.ev_class == EV_KEY && ev.event_code >= KEY_FIRST &&
             ev.event_code <= KEY_LAST && ev.event_value >= 0 && ev.event_value <= 2) begin
            res.result_kind = KIND_KEY;
            res.key_code = ev.event_code[9:0];
            res.key_state = ev.event_value[1:0];
            emits = 1'b1;
         end
         return;
      end
      if (ev.ev_class == EV_REL) begin
         case (ev.event_code)
            REL_X:       motion_x = clamp_add(motion_x, ev.event_value);
            REL_Y:       motion_y = clamp_add(motion_y, ev.event_value);
            REL_VSCROLL: wheel_v_sum = clamp_add(wheel_v_sum, ev.event_value);
            REL_HSCROLL: wheel_h_sum = clamp_add(wheel_h_sum, ev.event_value);
            default:     return;
         endcase
         report_waiting = 1'b1;
         return;
      end
      if (ev.ev_class == EV_KEY && ev.event_code >= BTN_FIRST && ev.event_code <= BTN_LAST) begin
         button_index = 3'(ev.event_code - BTN_FIRST);
         buttons_held[button_index] = (ev.event_value != 0);
         report_waiting = 1'b1;
         return;
      end
      // A sync report flushes the motion but keeps the buttons held.
      if (ev.ev_class == EV_SYN && ev.event_code == SYNC_FLUSH && report_waiting) begin
         res.result_kind = KIND_REPORT;
         res.delta_x = motion_x;
         res.delta_y = motion_y;
         res.wheel_vert = wheel_v_sum;
         res.wheel_horiz = wheel_h_sum;
         res.button_bits = buttons_held;
         motion_x = '0;
         motion_y = '0;
         wheel_v_sum = '0;
         wheel_h_sum = '0;
         report_waiting = 1'b0;
         emits = 1'b1;
      end
   endfunction

   task automatic flag_mismatch(input string field, input longint want, input longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
   endtask

   task automatic compare_result(input rsp_type want, input rsp_type got);
      if (got.result_kind !== want.result_kind)
         flag_mismatch("result_kind", longint'(want.result_kind), longint'(got.result_kind));
      if (got.stream_tag !== want.stream_tag)
         flag_mismatch("stream_tag", longint'(want.stream_tag), longint'(got.stream_tag));
      if (got.key_code !== want.key_code)
         flag_mismatch("key_code", longint'(want.key_code), longint'(got.key_code));
      if (got.key_state !== want.key_state)
         flag_mismatch("key_state", longint'(want.key_state), longint'(got.key_state));
      if (got.delta_x !== want.delta_x)
         flag_mismatch("delta_x", longint'(want.delta_x), longint'(got.delta_x));
      if (got.delta_y !== want.delta_y)
         flag_mismatch("delta_y", longint'(want.delta_y), longint'(got.delta_y));
      if (got.wheel_vert !== want.wheel_vert)
         flag_mismatch("wheel_vert", longint'(want.wheel_vert), longint'(got.wheel_vert));
      if (got.wheel_horiz !== want.wheel_horiz)
         flag_mismatch("wheel_horiz", longint'(want.wheel_horiz), longint'(got.wheel_horiz));
      if (got.button_bits !== want.button_bits)
         flag_mismatch("button_bits", longint'(want.button_bits), longint'(got.button_bits));
   endtask

   // Request driver. A request stays on the bus until the monitor has seen
   // it accepted; between requests it may insert a random idle burst.
   int gap_left = 0;
   always @(negedge clock) begin : request_driver
      event_req_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // Still waiting for the block to take the current request.
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (idling_on && event_backlog.size() != 0 && $urandom_range(0, 7) == 0) begin
         gap_left = $urandom_range(0, 10);
         req_valid <= 1'b0;
      end else if (event_backlog.size() != 0) begin
         next_item = event_backlog.pop_front();
         requests_issued++;
         req_valid <= 1'b1;
         req_source <= next_item.source;
         req_ev_class <= next_item.ev_class;
         req_event_code <= next_item.event_code;
         req_event_value <= next_item.event_value;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result receiver. Besides short random stalls it holds off once for a
   // long stretch while requests keep coming, so the block fills up and has
   // to drop req_ready.
   int  stall_left = 0;
   bit  long_hold_done = 1'b0;
   always @(negedge clock) begin : result_receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && requests_accepted >= LONG_HOLD_AT) begin
         long_hold_done = 1'b1;
         stall_left = LONG_HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor. Register writes, accepted requests and accepted results are
   // all sampled at the rising edge.
   always @(posedge clock) begin : channel_monitor
      event_req_type seen;
      rsp_type       want;
      rsp_type       got;
      bit            emits;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            tag_setting = csr_stream_id;
         end
         if (req_valid && !req_ready) begin
            backpressure_cycles++;
         end
         if (req_valid && req_ready) begin
            requests_accepted++;
            seen.source = req_source;
            seen.ev_class = req_ev_class;
            seen.event_code = req_event_code;
            seen.event_value = req_event_value;
            coalesce_event(seen, emits, want);
            if (emits) begin
               predicted_results.push_back(want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            got.result_kind = rsp_result_kind;
            got.stream_tag = rsp_stream_tag;
            got.key_code = rsp_key_code;
            got.key_state = rsp_key_state;
            got.delta_x = rsp_delta_x;
            got.delta_y = rsp_delta_y;
            got.wheel_vert = rsp_wheel_vert;
            got.wheel_horiz = rsp_wheel_horiz;
            got.button_bits = rsp_button_bits;
            if (predicted_results.size() == 0) begin
               $display("%0t: result with nothing expected, kind %0d", $time, rsp_result_kind);
               mismatch_count++;
            end else begin
               want = predicted_results.pop_front();
               compare_result(want, got);
               case (want.result_kind)
                  KIND_KEY:    key_results++;
                  KIND_REPORT: pointer_reports++;
                  default:     overflow_results++;
               endcase
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, predicted_results.size());
         $display("FAIL input_event_report_coalescer_core");
         $finish;
      end
   end

   task automatic queue_event(input logic src, input logic [4:0] etype,
                              input logic [15:0] code, input logic [31:0] value);
      event_req_type item;
      item.source = src;
      item.ev_class = etype;
      item.event_code = code;
      item.event_value = value;
      event_backlog.push_back(item);
      queued_events++;
   endtask

   // Random junk, biased toward the edges of the key and button ranges.
   // A dropped sync is never produced here since it would halt the block.
   task automatic queue_noise_event(input logic src);
      logic [4:0]  etype;
      logic [15:0] code;
      logic [31:0] value;
      etype = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 1) == 0) begin
         etype = 5'($urandom_range(EV_SYN, EV_REL));
      end
      case ($urandom_range(0, 3))
         0:       code = 16'($urandom_range(0, 10));
         1:       code = 16'($urandom_range(KEY_LAST - 7, KEY_LAST + 8));
         2:       code = 16'($urandom_range(BTN_FIRST - 2, BTN_LAST + 2));
         default: code = 16'($urandom);
      endcase
      value = $urandom;
      if ($urandom_range(0, 1) == 0) begin
         value = $urandom_range(0, 4) - 1;
      end
      if (etype == EV_SYN && code == SYNC_LOST) begin
         code = SYNC_FLUSH;
      end
      queue_event(src, etype, code, value);
   endtask

   // A pointer frame: a few moves and button changes, usually closed by a
   // sync report. Now and then the sync is left out or junk is mixed in.
   task automatic queue_pointer_frame();
      int          sel;
      int          mode;
      logic [15:0] code;
      logic [31:0] amount;
      repeat ($urandom_range(1, 6)) begin
         sel = $urandom_range(0, 8);
         if (sel < 4) begin
            case (sel)
               0:       code = REL_X;
               1:       code = REL_Y;
               2:       code = REL_VSCROLL;
               default: code = REL_HSCROLL;
            endcase
            mode = $urandom_range(0, 19);
            if (mode < 12) begin
               amount = $urandom_range(0, 128) - 64;
            end else if (mode < 17) begin
               amount = $urandom_range(0, 40000) - 20000;
            end else begin
               amount = $urandom;
            end
            queue_event(SRC_POINTER, EV_REL, code, amount);
         end else begin
            code = BTN_FIRST + 16'(sel - 4);
            amount = $urandom;
            if ($urandom_range(0, 1) == 0) begin
               amount = '0;
            end
            queue_event(SRC_POINTER, EV_KEY, code, amount);
         end
         if ($urandom_range(0, 15) == 0) begin
            queue_noise_event(1'($urandom_range(0, 1)));
         end
      end
      if ($urandom_range(0, 9) != 0) begin
         amount = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
         queue_event(SRC_POINTER, EV_SYN, SYNC_FLUSH, amount);
      end
   endtask

   task automatic queue_random_traffic(input int count);
      int target;
      int pick;
      target = queued_events + count;
      while (queued_events < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            queue_event(SRC_KEYBOARD, EV_KEY, 16'($urandom_range(KEY_FIRST, KEY_LAST)),
                        $urandom_range(0, 2));
         end else if (pick < 36) begin
            queue_noise_event(SRC_KEYBOARD);
         end else if (pick < 90) begin
            queue_pointer_frame();
         end else begin
            queue_noise_event(SRC_POINTER);
         end
      end
   endtask

   task automatic write_stream_id(input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_stream_id <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   // Waits until every queued request has been taken and every predicted
   // result has arrived, then gives the pipeline time to finish any request
   // that produced nothing.
   task automatic wait_for_drain();
      @(negedge clock);
      while (event_backlog.size() != 0 || requests_issued != requests_accepted ||
             predicted_results.size() != 0) @(negedge clock);
      repeat (LATENCY_SLACK) @(negedge clock);
   endtask

   initial begin : main_sequence
      int phase;
      logic [31:0] phase_tags[5];
      phase_tags[0] = 32'h0000_0000;
      phase_tags[1] = $urandom;
      phase_tags[2] = 32'h8000_0000;
      phase_tags[3] = 32'h0000_0001;
      phase_tags[4] = $urandom;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed events with the stream id at its all-ones extreme.
      write_stream_id(32'hFFFF_FFFF);
      idling_on = 1'b1;
      queue_event(SRC_KEYBOARD, EV_KEY, KEY_FIRST, 32'd0);         // release, lowest key
      queue_event(SRC_KEYBOARD, EV_KEY, KEY_LAST, 32'd1);          // press, highest key
      queue_event(SRC_KEYBOARD, EV_KEY, 16'h02AA, 32'd2);          // autorepeat
      queue_event(SRC_KEYBOARD, EV_KEY, 16'd0, 32'd1);             // key code below range
      queue_event(SRC_KEYBOARD, EV_KEY, 16'(KEY_LAST + 1), 32'd1); // key code above range
      queue_event(SRC_KEYBOARD, EV_KEY, 16'd30, 32'd3);            // state out of range
      queue_event(SRC_KEYBOARD, EV_KEY, 16'd30, 32'hFFFF_FFFF);    // negative state
      queue_event(SRC_KEYBOARD, EV_REL, REL_X, 32'd5);             // keyboard motion ignored
      queue_event(SRC_KEYBOARD, EV_SYN, SYNC_FLUSH, 32'd0);        // keyboard sync ignored
      queue_event(SRC_POINTER, EV_SYN, SYNC_FLUSH, 32'd0);         // sync with nothing pending
      queue_event(SRC_POINTER, EV_REL, REL_X, 32'h7FFF_FFFF);      // saturate high
      queue_event(SRC_POINTER, EV_REL, REL_X, 32'd1);              // stays at the rail
      queue_event(SRC_POINTER, EV_REL, REL_Y, 32'h8000_0000);      // saturate low
      queue_event(SRC_POINTER, EV_REL, REL_VSCROLL, 32'hFFFF_FFFD);
      queue_event(SRC_POINTER, EV_REL, REL_HSCROLL, 32'd7);
      queue_event(SRC_POINTER, EV_REL, 16'd2, 32'd100);            // unknown relative axis
      queue_event(SRC_POINTER, EV_KEY, BTN_FIRST, 32'd1);          // left down
      queue_event(SRC_POINTER, EV_KEY, BTN_LAST, 32'hFFFF_FFFB);   // extra down, negative value
      queue_event(SRC_POINTER, EV_KEY, 16'(BTN_FIRST + 2), 32'd0); // middle up while already up
      queue_event(SRC_POINTER, EV_KEY, 16'(BTN_LAST + 1), 32'd1);  // past the last button
      queue_event(SRC_POINTER, 5'd31, 16'hFFFF, 32'h5A5A_A5A5);    // unknown type
      queue_event(SRC_POINTER, EV_SYN, SYNC_FLUSH, 32'd0);         // full report
      queue_event(SRC_POINTER, EV_KEY, BTN_FIRST, 32'd0);          // left up
      queue_event(SRC_POINTER, EV_SYN, SYNC_FLUSH, 32'd0);         // buttons kept, no motion
      queue_event(SRC_POINTER, EV_SYN, 16'd1, 32'd0);              // other sync code ignored
      wait_for_drain();

      // Random phases, each under its own stream id. Phases 2 and 4 run
      // without idling on either side; the last one leads into the tail.
      for (phase = 0; phase < 5; phase++) begin
         write_stream_id(phase_tags[phase]);
         idling_on = (phase != 2 && phase != 4);
         queue_random_traffic(ITEMS_PER_PHASE);
         wait_for_drain();
      end

      // The dropped sync halts the block for good; what follows must be
      // swallowed without any result.
      write_stream_id($urandom);
      queue_event(1'($urandom_range(0, 1)), EV_SYN, SYNC_LOST, $urandom);
      queue_event(SRC_KEYBOARD, EV_KEY, 16'd30, 32'd1);
      queue_pointer_frame();
      queue_event(SRC_POINTER, EV_SYN, SYNC_LOST, 32'd0);
      wait_for_drain();

      $display("Covered %0d requests: %0d key results, %0d pointer reports, %0d overflow errors.",
               requests_accepted, key_results, pointer_reports, overflow_results);
      $display("%0d stream id writes; input held off by back-pressure for %0d cycles.",
               csr_writes, backpressure_cycles);
      if (mismatch_count == 0) begin
         $display("PASS input_event_report_coalescer_core");
      end else begin
         $display("FAIL input_event_report_coalescer_core");
      end
      $finish;
   end

endmodule

/* files.f */
src/iercoal_pkg.sv
src/iercoal_in_stage.sv
src/iercoal_engine.sv
src/iercoal_out_stage.sv
src/input_event_report_coalescer_core.sv
tb/tb.sv
